// ===== rtl/lek_pkg.sv =====
// ---------------------------------------------------------------------------
// Line editor package
// Shared types, constants and state codes of the line editor.
// ---------------------------------------------------------------------------
package lek_pkg;

	localparam int MAX_LENGTH = 32;
	localparam int ADDR_W     = $clog2(MAX_LENGTH);
	localparam int LEN_W      = 6;
	localparam int TIME_W     = 32;
	localparam int TICK_W     = 16;
	localparam int CHAR_W     = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(32);
	localparam logic [LEN_W-1:0]  LEN_FULL   = LEN_W'(MAX_LENGTH);

	localparam logic [TICK_W-1:0] DELAY_RESET    = TICK_W'(400);
	localparam logic [TICK_W-1:0] INTERVAL_RESET = TICK_W'(30);

	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_FRAME = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FR_ADD,
		ST_FR_DLY,
		ST_FR_DIFF,
		ST_FR_INT,
		ST_EDIT,
		ST_RM_CHK,
		ST_RM_SRD,
		ST_RM_SWR,
		ST_RM_END,
		ST_CURSOR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [CHAR_W-1:0] char_code;
		logic [TICK_W-1:0] elapsed_ticks;
		logic              backspace_key;
		logic              delete_key;
		logic              left_key;
		logic              right_key;
		logic              home_key;
		logic              end_key;
		logic [4:0]        read_index;
	} in_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  text_length;
		logic [LEN_W-1:0]  cursor_pos;
		logic              has_non_blank;
		logic [CHAR_W-1:0] read_byte;
		logic              edit_fired;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

endpackage

// ===== rtl/lek_ifs.sv =====
// ---------------------------------------------------------------------------
// Line editor channels
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
interface lek_in_if;
	import lek_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lek_out_if;
	import lek_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lek_cfg_if;
	import lek_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [TICK_W-1:0]    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/line_editor_with_key_repeat.sv =====
// ---------------------------------------------------------------------------
// Line editor with key repeat
// Single-line text buffer with cursor, edit-key autorepeat and byte reads.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time and returns one result for it.
// The line sits in a memory with one read and one write port and a
// registered read, so every byte moved by an insert or a removal costs one
// read state and one write state, and the hold timer checks run one step per
// cycle through a single 32-bit adder. A finished result waits in an output
// register while the next transaction is accepted.
// ---------------------------------------------------------------------------
module line_editor_with_key_repeat (
	input logic clk,
	input logic arst_n,
	lek_in_if.sink   items,
	lek_out_if.source results,
	lek_cfg_if.sink  cfg
);
	import lek_pkg::*;

	state_t state_q, state_d;

	in_item_t          item_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  cursor_q;
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  idx_q;
	logic [TIME_W-1:0] held_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] diff_q;
	logic [TICK_W-1:0] delay_q;
	logic [TICK_W-1:0] interval_q;
	logic [CHAR_W-1:0] rbyte_q;
	logic              fired_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [CHAR_W-1:0] mem [MAX_LENGTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic              wr_en;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic              accept;
	logic              out_load;
	logic [LEN_W-1:0]  idx_dec;
	logic [LEN_W-1:0]  idx_inc;
	logic [LEN_W-1:0]  idx_inc2;
	logic [LEN_W-1:0]  cursor_dec;
	logic              edit_bs;
	logic              edit_del;
	logic [LEN_W-1:0]  edit_pos;
	logic              char_ok;
	logic signed [LEN_W+1:0] cur_step;
	logic [LEN_W-1:0]  cur_final;

	lek_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign items.ready   = (state_q == ST_IDLE);
	assign accept        = items.valid && items.ready;
	assign cfg.ready     = 1'b1;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	assign idx_dec    = idx_q - LEN_W'(1);
	assign idx_inc    = idx_q + LEN_W'(1);
	assign idx_inc2   = idx_q + LEN_W'(2);
	assign cursor_dec = cursor_q - LEN_W'(1);
	assign edit_bs    = item_q.backspace_key && (cursor_q != '0);
	assign edit_del   = item_q.delete_key && (cursor_q < length_q);
	assign edit_pos   = edit_bs ? cursor_dec : cursor_q;
	assign char_ok    = (length_q < LEN_FULL) && (items.data.char_code >= SPACE_CHAR);

	always_comb begin
		cur_step = $signed({2'b00, cursor_q});
		if (item_q.left_key) begin
			cur_step = cur_step - 8'sd1;
		end
		if (item_q.right_key) begin
			cur_step = cur_step + 8'sd1;
		end
		if (item_q.home_key) begin
			cur_step = '0;
		end
		if (item_q.end_key) begin
			cur_step = $signed({2'b00, length_q});
		end
		if (cur_step < 0) begin
			cur_final = '0;
		end else if (cur_step > $signed({2'b00, length_q})) begin
			cur_final = length_q;
		end else begin
			cur_final = cur_step[LEN_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_dec[ADDR_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[ADDR_W-1:0];
		wr_data = rd_data_q;
		alu_req = '{a: held_q, b: {{(TIME_W-TICK_W){1'b0}}, item_q.elapsed_ticks}, sub: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(items.data.operation))
						OP_CHAR: begin
							if (!char_ok) begin
								state_d = ST_DONE;
							end else if (cursor_q == length_q) begin
								state_d = ST_INS_PUT;
							end else begin
								state_d = ST_INS_RD;
							end
						end
						OP_FRAME: begin
							if (items.data.backspace_key || items.data.delete_key) begin
								state_d = ST_FR_ADD;
							end else begin
								state_d = ST_CURSOR;
							end
						end
						OP_READ: state_d = ST_RD_ADDR;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD: begin
				rd_addr = idx_dec[ADDR_W-1:0];
				state_d = ST_INS_WR;
			end
			ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[ADDR_W-1:0];
				wr_data = rd_data_q;
				state_d = (idx_dec == cursor_q) ? ST_INS_PUT : ST_INS_RD;
			end
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = cursor_q[ADDR_W-1:0];
				wr_data = item_q.char_code;
				state_d = ST_DONE;
			end
			ST_RD_ADDR: begin
				rd_addr = item_q.read_index[ADDR_W-1:0];
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: state_d = ST_DONE;
			ST_FR_ADD: begin
				alu_req = '{a: held_q,
					b: {{(TIME_W-TICK_W){1'b0}}, item_q.elapsed_ticks}, sub: 1'b0};
				state_d = (held_q == '0) ? ST_EDIT : ST_FR_DLY;
			end
			ST_FR_DLY: begin
				alu_req = '{a: held_q, b: {{(TIME_W-TICK_W){1'b0}}, delay_q}, sub: 1'b1};
				state_d = alu_rsp.carry ? ST_FR_DIFF : ST_CURSOR;
			end
			ST_FR_DIFF: begin
				alu_req = '{a: held_q, b: last_q, sub: 1'b1};
				state_d = ST_FR_INT;
			end
			ST_FR_INT: begin
				alu_req = '{a: diff_q, b: {{(TIME_W-TICK_W){1'b0}}, interval_q}, sub: 1'b1};
				state_d = alu_rsp.carry ? ST_EDIT : ST_CURSOR;
			end
			ST_EDIT: begin
				rd_addr = edit_pos[ADDR_W-1:0];
				state_d = (edit_bs || edit_del) ? ST_RM_CHK : ST_CURSOR;
			end
			ST_RM_CHK: state_d = (idx_inc < length_q) ? ST_RM_SRD : ST_RM_END;
			ST_RM_SRD: begin
				rd_addr = idx_inc[ADDR_W-1:0];
				state_d = ST_RM_SWR;
			end
			ST_RM_SWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[ADDR_W-1:0];
				wr_data = rd_data_q;
				state_d = (idx_inc2 < length_q) ? ST_RM_SRD : ST_RM_END;
			end
			ST_RM_END: state_d = ST_CURSOR;
			ST_CURSOR: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.reg_index == REG_DELAY) begin
				delay_q <= cfg.wdata;
			end
			if (cfg.reg_index == REG_INTERVAL) begin
				interval_q <= cfg.wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q  <= items.data;
					idx_q   <= length_q;
					rbyte_q <= '0;
					fired_q <= 1'b0;
				end
			end
			ST_INS_WR: idx_q <= idx_dec;
			ST_RD_DATA: begin
				if ({1'b0, item_q.read_index} < length_q) begin
					rbyte_q <= rd_data_q;
				end
			end
			ST_FR_DIFF: diff_q <= alu_rsp.sum;
			ST_EDIT: begin
				idx_q <= edit_pos;
				if (edit_bs || edit_del) begin
					fired_q <= 1'b1;
				end
			end
			ST_RM_SWR: idx_q <= idx_inc;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			cursor_q <= '0;
			count_q  <= '0;
			held_q   <= '0;
			last_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (op_t'(items.data.operation) == OP_FRAME)
						&& !(items.data.backspace_key || items.data.delete_key)) begin
						held_q <= '0;
						last_q <= '0;
					end
				end
				ST_INS_PUT: begin
					length_q <= length_q + LEN_W'(1);
					cursor_q <= cursor_q + LEN_W'(1);
					if (item_q.char_code != SPACE_CHAR) begin
						count_q <= count_q + LEN_W'(1);
					end
				end
				ST_FR_ADD: begin
					held_q <= alu_rsp.carry ? '1 : alu_rsp.sum;
					if (held_q == '0) begin
						last_q <= '0;
					end
				end
				ST_FR_INT: begin
					if (alu_rsp.carry) begin
						last_q <= held_q;
					end
				end
				ST_EDIT: begin
					if (edit_bs) begin
						cursor_q <= cursor_dec;
					end
				end
				ST_RM_CHK: begin
					if ((rd_data_q != SPACE_CHAR) && (count_q != '0)) begin
						count_q <= count_q - LEN_W'(1);
					end
				end
				ST_RM_END: length_q <= length_q - LEN_W'(1);
				ST_CURSOR: cursor_q <= cur_final;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.text_length   <= length_q;
			out_q.cursor_pos    <= cursor_q;
			out_q.has_non_blank <= (count_q != '0);
			out_q.read_byte     <= rbyte_q;
			out_q.edit_fired    <= fired_q;
		end
	end

endmodule

// ===== rtl/lek_alu.sv =====
// ---------------------------------------------------------------------------
// Line editor timer adder
// Shared 32-bit adder/subtractor with carry out, used for every timer step.
// ---------------------------------------------------------------------------
module lek_alu (
	input  lek_pkg::alu_req_t req,
	output lek_pkg::alu_rsp_t rsp
);
	import lek_pkg::*;

	logic [TIME_W:0] total;

	// For a subtraction the carry out is set when no borrow occurs.
	assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
		+ {{TIME_W{1'b0}}, req.sub};

	assign rsp.sum   = total[TIME_W-1:0];
	assign rsp.carry = total[TIME_W];

endmodule

// ===== test/line_editor_with_key_repeat_tb.sv =====
// ---------------------------------------------------------------------------
// Line editor with key repeat testbench
// Drives typed characters, key frames and byte reads through the item
// channel. Timing registers are changed between phases while the block is
// idle, and both sides of the handshake stall at random. Each result is
// compared field by field with a line model kept inside the bench, or with
// values set in the script. A short scripted opening covers corner cases;
// random typing, held edit keys, cursor moves, reads and raw items follow.
// ---------------------------------------------------------------------------
module line_editor_with_key_repeat_tb;
	import lek_pkg::*;

	localparam logic [5:0] K_NONE  = 6'b000000;
	localparam logic [5:0] K_BS    = 6'b100000;
	localparam logic [5:0] K_DEL   = 6'b010000;
	localparam logic [5:0] K_LEFT  = 6'b001000;
	localparam logic [5:0] K_RIGHT = 6'b000100;
	localparam logic [5:0] K_HOME  = 6'b000010;
	localparam logic [5:0] K_END   = 6'b000001;

	localparam out_item_t NO_WANT = '0;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [TICK_W-1:0] ticks;
		logic [5:0]        keys;
		logic [4:0]        idx;
		logic              typed;
		out_item_t         want;
	} script_row_t;

	localparam script_row_t SCRIPT [25] = '{
		'{OP_READ,  8'd0,   16'd0,      K_NONE,                  5'd0,  1'b1, NO_WANT},
		'{OP_READ,  8'd0,   16'd0,      K_NONE,                  5'd31, 1'b1, NO_WANT},
		'{OP_NONE,  8'hFF,  16'hFFFF,   6'h3F,                   5'd31, 1'b1, NO_WANT},
		'{OP_CHAR,  8'd31,  16'd0,      K_NONE,                  5'd0,  1'b1, NO_WANT},
		'{OP_CHAR,  8'd0,   16'd0,      K_NONE,                  5'd0,  1'b1, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd0,      K_BS,                    5'd0,  1'b1, NO_WANT},
		'{OP_FRAME, 8'd0,   16'hFFFF,   K_LEFT | K_RIGHT | K_HOME | K_END, 5'd0, 1'b1,
			NO_WANT},
		'{OP_CHAR,  8'd32,  16'd0,      K_NONE,                  5'd0,  1'b1,
			'{6'd1, 6'd1, 1'b0, 8'd0, 1'b0}},
		'{OP_CHAR,  8'd255, 16'd0,      K_NONE,                  5'd0,  1'b1,
			'{6'd2, 6'd2, 1'b1, 8'd0, 1'b0}},
		'{OP_CHAR,  8'd126, 16'd0,      K_NONE,                  5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd5,      K_LEFT,                  5'd0,  1'b0, NO_WANT},
		'{OP_CHAR,  8'd65,  16'd0,      K_NONE,                  5'd0,  1'b0, NO_WANT},
		'{OP_READ,  8'd0,   16'd0,      K_NONE,                  5'd2,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd0,      K_BS,                    5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd0,      K_BS,                    5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd100,    K_BS | K_DEL,            5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd299,    K_DEL,                   5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd1,      K_DEL,                   5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd29,     K_DEL,                   5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd1,      K_DEL | K_HOME,          5'd0,  1'b0, NO_WANT},
		'{OP_CHAR,  8'd88,  16'd0,      K_NONE,                  5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd7,      K_HOME,                  5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'd3,      K_BS | K_DEL,            5'd0,  1'b0, NO_WANT},
		'{OP_FRAME, 8'd0,   16'h8000,   K_END | K_LEFT | K_RIGHT, 5'd0, 1'b0, NO_WANT},
		'{OP_READ,  8'd0,   16'd0,      K_NONE,                  5'd5,  1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	lek_in_if  item_ch ();
	lek_out_if result_ch ();
	lek_cfg_if cfg_ch ();

	line_editor_with_key_repeat i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	always #1 clk = ~clk;

	logic [CHAR_W-1:0] line_mem [MAX_LENGTH];
	int                line_len;
	int                cursor_at;
	int                non_space;
	logic [TIME_W-1:0] hold_ticks;
	logic [TIME_W-1:0] last_fire;
	logic [TICK_W-1:0] delay_ticks;
	logic [TICK_W-1:0] interval_ticks;

	out_item_t pending_status [$];
	int        mismatches   = 0;
	int        sent_items   = 0;
	int        results_seen = 0;
	bit        sender_fast  = 1'b0;

	function automatic in_item_t make_item(op_t op, logic [CHAR_W-1:0] ch,
		logic [TICK_W-1:0] ticks, logic [5:0] keys, logic [4:0] idx);
		in_item_t it;
		it.operation     = op;
		it.char_code     = ch;
		it.elapsed_ticks = ticks;
		{it.backspace_key, it.delete_key, it.left_key, it.right_key, it.home_key,
			it.end_key} = keys;
		it.read_index    = idx;
		return it;
	endfunction

	function automatic bit hold_fires(logic [TICK_W-1:0] dt);
		logic [TIME_W-1:0] prev;
		logic [TIME_W:0]   sum;
		prev = hold_ticks;
		sum = {1'b0, hold_ticks} + dt;
		hold_ticks = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		if (prev == '0) begin
			last_fire = '0;
			return 1'b1;
		end
		if (hold_ticks < delay_ticks)
			return 1'b0;
		if (hold_ticks - last_fire < interval_ticks)
			return 1'b0;
		last_fire = hold_ticks;
		return 1'b1;
	endfunction

	function automatic void drop_byte(int pos);
		int i;
		if (pos >= line_len)
			return;
		if (line_mem[pos] != SPACE_CHAR && non_space > 0)
			non_space--;
		for (i = pos; i < line_len - 1; i++)
			line_mem[i] = line_mem[i + 1];
		line_len--;
		line_mem[line_len] = '0;
	endfunction

	function automatic out_item_t edit_line(in_item_t it);
		out_item_t         res;
		logic [CHAR_W-1:0] rb;
		logic              fired;
		int                c;
		int                i;
		rb = '0;
		fired = 1'b0;
		if (cursor_at > line_len)
			cursor_at = line_len;
		case (op_t'(it.operation))
			OP_CHAR: begin
				if (line_len < MAX_LENGTH && it.char_code >= SPACE_CHAR) begin
					for (i = line_len; i > cursor_at; i--)
						line_mem[i] = line_mem[i - 1];
					line_mem[cursor_at] = it.char_code;
					line_len++;
					cursor_at++;
					if (it.char_code != SPACE_CHAR)
						non_space++;
				end
			end
			OP_FRAME: begin
				if (!(it.backspace_key || it.delete_key)) begin
					hold_ticks = '0;
					last_fire = '0;
				end else if (hold_fires(it.elapsed_ticks)) begin
					if (it.backspace_key && cursor_at > 0) begin
						drop_byte(cursor_at - 1);
						cursor_at--;
						fired = 1'b1;
					end else if (it.delete_key && cursor_at < line_len) begin
						drop_byte(cursor_at);
						fired = 1'b1;
					end
				end
				c = cursor_at;
				if (it.left_key)
					c--;
				if (it.right_key)
					c++;
				if (it.home_key)
					c = 0;
				if (it.end_key)
					c = line_len;
				if (c < 0)
					c = 0;
				if (c > line_len)
					c = line_len;
				cursor_at = c;
			end
			OP_READ: begin
				if (int'(it.read_index) < line_len)
					rb = line_mem[it.read_index];
			end
			default: ;
		endcase
		res.text_length   = LEN_W'(line_len);
		res.cursor_pos    = LEN_W'(cursor_at);
		res.has_non_blank = (non_space > 0);
		res.read_byte     = rb;
		res.edit_fired    = fired;
		return res;
	endfunction

	function automatic logic [TICK_W-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return TICK_W'($urandom_range(0, 8));
		if (r < 6)
			return TICK_W'($urandom_range(0, int'(interval_ticks) + 4));
		if (r < 8)
			return TICK_W'($urandom_range(0, int'(delay_ticks) / 4 + 4));
		if (r < 9)
			return TICK_W'($urandom_range(0, 2000));
		return TICK_W'($urandom());
	endfunction

	task automatic send_item(in_item_t it, logic typed, out_item_t want);
		out_item_t predicted;
		int        r;
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predicted = edit_line(it);
		pending_status.push_back(typed ? want : predicted);
		sent_items++;
		r = $urandom_range(0, 99);
		if (!sender_fast && r >= 55) begin
			item_ch.valid <= 1'b0;
			repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(15, 60))
				@(posedge clk);
		end
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic set_timing(logic [TICK_W-1:0] dly, logic [TICK_W-1:0] ivl);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= REG_DELAY;
		cfg_ch.wdata     <= dly;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		delay_ticks = dly;
		cfg_ch.reg_index <= REG_INTERVAL;
		cfg_ch.wdata     <= ivl;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		interval_ticks = ivl;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Each accepted transaction is checked against the oldest prediction.
	initial begin : result_sink
		out_item_t want;
		int        hold_left;
		int        r;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (pending_status.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_ch.data);
					mismatches++;
				end else begin
					want = pending_status.pop_front();
					check_field("text_length", want.text_length, result_ch.data.text_length);
					check_field("cursor_pos", want.cursor_pos, result_ch.data.cursor_pos);
					check_field("has_non_blank", want.has_non_blank,
						result_ch.data.has_non_blank);
					check_field("read_byte", want.read_byte, result_ch.data.read_byte);
					check_field("edit_fired", want.edit_fired, result_ch.data.edit_fired);
				end
				results_seen++;
				if (results_seen == 150 || results_seen == 520)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (results_seen % 128 < 24) begin
				result_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					result_ch.ready <= 1'b1;
				end else begin
					result_ch.ready <= 1'b0;
					hold_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(15, 60);
				end
			end
		end
	end

	initial begin : run_limit
		#1200000;
		$display("FAIL line_editor_with_key_repeat");
		$finish;
	end

	initial begin : stimulus
		script_row_t       row;
		in_item_t          it;
		logic [63:0]       raw;
		logic [5:0]        edit_keys;
		logic [TICK_W-1:0] dly;
		logic [TICK_W-1:0] ivl;
		logic [CHAR_W-1:0] ch;
		int                phase;
		int                target;
		int                kind;
		int                n;
		int                j;
		int                r;

		item_ch.valid    <= 1'b0;
		item_ch.data     <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.reg_index <= REG_DELAY;
		cfg_ch.wdata     <= '0;
		arst_n           <= 1'b0;

		foreach (line_mem[i])
			line_mem[i] = '0;
		line_len = 0;
		cursor_at = 0;
		non_space = 0;
		hold_ticks = '0;
		last_fire = '0;
		delay_ticks = DELAY_RESET;
		interval_ticks = INTERVAL_RESET;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		for (j = 0; j < $size(SCRIPT); j++) begin
			row = SCRIPT[j];
			send_item(make_item(row.op, row.ch, row.ticks, row.keys, row.idx), row.typed,
				row.want);
		end
		settle();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin dly = 16'd0;     ivl = 16'd0;     end
				1: begin dly = 16'hFFFF;  ivl = 16'hFFFF;  end
				2: begin dly = 16'd20;    ivl = 16'd5;     end
				3: begin dly = 16'd0;     ivl = 16'hFFFF;  end
				4: begin dly = 16'hFFFF;  ivl = 16'd0;     end
				5: begin dly = TICK_W'($urandom()); ivl = TICK_W'($urandom()); end
				6: begin
					dly = TICK_W'($urandom_range(0, 60));
					ivl = TICK_W'($urandom_range(0, 20));
				end
				default: begin dly = DELAY_RESET; ivl = INTERVAL_RESET; end
			endcase
			set_timing(dly, ivl);
			target = sent_items + 95;
			while (sent_items < target) begin
				sender_fast = ($urandom_range(0, 99) < 15);
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 40)
						: $urandom_range(1, 12);
					for (j = 0; j < n; j++) begin
						r = $urandom_range(0, 9);
						if (r < 7)
							ch = CHAR_W'($urandom_range(33, 126));
						else if (r < 8)
							ch = SPACE_CHAR;
						else if (r < 9)
							ch = CHAR_W'($urandom_range(0, 31));
						else
							ch = CHAR_W'($urandom_range(128, 255));
						send_item(make_item(OP_CHAR, ch, TICK_W'($urandom()), 6'($urandom()),
							5'($urandom())), 1'b0, NO_WANT);
					end
				end else if (kind < 60) begin
					edit_keys = {2'($urandom_range(1, 3)), 4'b0000};
					n = $urandom_range(1, 25);
					for (j = 0; j < n; j++) begin
						send_item(make_item(OP_FRAME, CHAR_W'($urandom()), pick_ticks(),
							($urandom_range(0, 4) == 0) ? edit_keys | 6'($urandom_range(0, 15))
							: edit_keys, 5'($urandom())), 1'b0, NO_WANT);
					end
					send_item(make_item(OP_FRAME, CHAR_W'($urandom()), pick_ticks(),
						6'($urandom_range(0, 15)), 5'($urandom())), 1'b0, NO_WANT);
				end else if (kind < 72) begin
					n = $urandom_range(1, 4);
					for (j = 0; j < n; j++)
						send_item(make_item(OP_FRAME, CHAR_W'($urandom()), pick_ticks(),
							6'($urandom_range(0, 15)), 5'($urandom())), 1'b0, NO_WANT);
				end else if (kind < 85) begin
					n = $urandom_range(1, 4);
					for (j = 0; j < n; j++) begin
						if (line_len > 0 && $urandom_range(0, 3) != 0)
							r = $urandom_range(0, line_len - 1);
						else
							r = $urandom_range(0, 31);
						send_item(make_item(OP_READ, CHAR_W'($urandom()), TICK_W'($urandom()),
							6'($urandom()), 5'(r)), 1'b0, NO_WANT);
					end
				end else begin
					n = $urandom_range(1, 3);
					for (j = 0; j < n; j++) begin
						raw = {$urandom(), $urandom()};
						it = raw[$bits(in_item_t)-1:0];
						send_item(it, 1'b0, NO_WANT);
					end
				end
			end
			settle();
		end

		repeat (80)
			@(posedge clk);
		if (mismatches == 0)
			$display("PASS line_editor_with_key_repeat");
		else
			$display("FAIL line_editor_with_key_repeat");
		$finish;
	end

endmodule
